[rtl/scl_pkg.sv]
`default_nettype none

package scl_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_QUOTE      = 8'h27;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    typedef enum logic [2:0] {
        MODE_START  = 3'd0,
        MODE_IDENT  = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_STRING = 3'd3,
        MODE_OTHER  = 3'd4
    } scan_mode_t;

    typedef enum logic [2:0] {
        CLS_IDENT  = 3'd0,
        CLS_NUMBER = 3'd1,
        CLS_STRING = 3'd2,
        CLS_OTHER  = 3'd3,
        CLS_EOS    = 3'd4
    } tok_class_t;

    typedef enum logic [2:0] {
        CHR_BLANK,
        CHR_QUOTE,
        CHR_NEWLINE,
        CHR_WORD,
        CHR_DIGIT,
        CHR_OTHER
    } chr_kind_t;

    typedef struct packed {
        logic       is_end;
        tok_class_t token_class;
        logic [7:0] char_value;
        logic       unterminated;
        logic       last_of_run;
    } result_t;

    // All results caused by one input byte.
    typedef struct packed {
        result_t r0;
        result_t r1;
        logic    two;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
    } front_out_t;

    // Letters and underscore start or continue a word; digits are kept apart.
    function automatic chr_kind_t classify(input logic [7:0] ch);
        chr_kind_t k;
        if (ch == 8'h20 || ch == 8'h09 || ch == 8'h0B || ch == 8'h0C || ch == 8'h0D) begin
            k = CHR_BLANK;
        end
        else if (ch == CH_QUOTE) begin
            k = CHR_QUOTE;
        end
        else if (ch == CH_NEWLINE) begin
            k = CHR_NEWLINE;
        end
        else if ((ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A)
                 || ch == CH_UNDERSCORE) begin
            k = CHR_WORD;
        end
        else if (ch >= 8'h30 && ch <= 8'h39) begin
            k = CHR_DIGIT;
        end
        else begin
            k = CHR_OTHER;
        end
        return k;
    endfunction

    function automatic result_t make_result(input logic is_end, input tok_class_t cls,
                                            input logic [7:0] ch, input logic unterm);
        result_t r;
        r.is_end       = is_end;
        r.token_class  = cls;
        r.char_value   = ch;
        r.unterminated = unterm;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/scl_front.sv]
`default_nettype none

module scl_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [7:0]          char_code,
    output scl_pkg::front_out_t      front_out
);

    scl_pkg::scan_mode_t mode_reg;
    scl_pkg::scan_mode_t mode_next;
    scl_pkg::chr_kind_t  kind;

    assign kind = scl_pkg::classify(char_code);

    // A token that cannot take this byte ends, and the byte starts afresh.
    logic fresh;

    always_comb
    begin
        fresh = 1'b0;
        case (mode_reg)
            scl_pkg::MODE_IDENT:
                fresh = !(kind == scl_pkg::CHR_WORD || kind == scl_pkg::CHR_DIGIT);
            scl_pkg::MODE_NUMBER:
                fresh = (kind != scl_pkg::CHR_DIGIT);
            scl_pkg::MODE_STRING:
                fresh = (kind == scl_pkg::CHR_NEWLINE);
            default:
                fresh = 1'b1;
        endcase
    end

    // Next state.
    always_comb
    begin
        mode_next = mode_reg;
        if (mode_reg == scl_pkg::MODE_STRING && kind == scl_pkg::CHR_QUOTE) begin
            mode_next = scl_pkg::MODE_START;
        end
        else if (fresh) begin
            case (kind)
                scl_pkg::CHR_QUOTE: mode_next = scl_pkg::MODE_STRING;
                scl_pkg::CHR_WORD:  mode_next = scl_pkg::MODE_IDENT;
                scl_pkg::CHR_DIGIT: mode_next = scl_pkg::MODE_NUMBER;
                scl_pkg::CHR_OTHER: mode_next = scl_pkg::MODE_OTHER;
                default:            mode_next = scl_pkg::MODE_START;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= scl_pkg::MODE_START;
        end
        else if (accept) begin
            mode_reg <= mode_next;
        end
    end

    // Outputs.
    scl_pkg::result_t first_res;
    scl_pkg::result_t fresh_res;
    logic             has_first;
    logic             has_fresh;

    always_comb
    begin
        has_first = 1'b0;
        first_res = scl_pkg::make_result(1'b0, scl_pkg::CLS_IDENT, 8'h00, 1'b0);
        case (mode_reg)
            scl_pkg::MODE_IDENT:
            begin
                has_first = 1'b1;
                first_res = fresh ? scl_pkg::make_result(1'b1, scl_pkg::CLS_IDENT, 8'h00, 1'b0)
                                  : scl_pkg::make_result(1'b0, scl_pkg::CLS_IDENT, char_code,
                                                         1'b0);
            end
            scl_pkg::MODE_NUMBER:
            begin
                has_first = 1'b1;
                first_res = fresh ? scl_pkg::make_result(1'b1, scl_pkg::CLS_NUMBER, 8'h00, 1'b0)
                                  : scl_pkg::make_result(1'b0, scl_pkg::CLS_NUMBER, char_code,
                                                         1'b0);
            end
            scl_pkg::MODE_STRING:
            begin
                has_first = 1'b1;
                if (kind == scl_pkg::CHR_QUOTE) begin
                    first_res = scl_pkg::make_result(1'b1, scl_pkg::CLS_STRING, 8'h00, 1'b0);
                end
                else if (kind == scl_pkg::CHR_NEWLINE) begin
                    first_res = scl_pkg::make_result(1'b1, scl_pkg::CLS_STRING, 8'h00, 1'b1);
                end
                else begin
                    first_res = scl_pkg::make_result(1'b0, scl_pkg::CLS_STRING, char_code, 1'b0);
                end
            end
            scl_pkg::MODE_OTHER:
            begin
                has_first = 1'b1;
                first_res = scl_pkg::make_result(1'b1, scl_pkg::CLS_OTHER, 8'h00, 1'b0);
            end
            default:
            begin
                has_first = 1'b0;
            end
        endcase

        has_fresh = 1'b0;
        fresh_res = scl_pkg::make_result(1'b0, scl_pkg::CLS_OTHER, char_code, 1'b0);
        if (fresh) begin
            case (kind)
                scl_pkg::CHR_NEWLINE:
                begin
                    has_fresh = 1'b1;
                    fresh_res = scl_pkg::make_result(1'b1, scl_pkg::CLS_EOS, 8'h00, 1'b0);
                end
                scl_pkg::CHR_WORD:
                begin
                    has_fresh = 1'b1;
                    fresh_res = scl_pkg::make_result(1'b0, scl_pkg::CLS_IDENT, char_code, 1'b0);
                end
                scl_pkg::CHR_DIGIT:
                begin
                    has_fresh = 1'b1;
                    fresh_res = scl_pkg::make_result(1'b0, scl_pkg::CLS_NUMBER, char_code, 1'b0);
                end
                scl_pkg::CHR_OTHER:
                begin
                    has_fresh = 1'b1;
                end
                default:
                begin
                    has_fresh = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        front_out.push      = accept && (has_first || has_fresh);
        front_out.entry.two = has_first && has_fresh;
        front_out.entry.r0  = has_first ? first_res : fresh_res;
        front_out.entry.r1  = fresh_res;
        front_out.entry.r0.last_of_run = !(has_first && has_fresh);
        front_out.entry.r1.last_of_run = 1'b1;
    end

endmodule

`default_nettype wire

[rtl/scl_queue.sv]
`default_nettype none

module scl_queue #(
    parameter int Depth = scl_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire scl_pkg::entry_t wr_data,
    output logic                 full,
    input  wire logic            rd_en,
    output scl_pkg::entry_t      rd_data,
    output logic                 rd_valid
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    scl_pkg::entry_t mem [Depth];

    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign full     = (count_reg == CntW'(Depth));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + CntW'(1);
        end
        else if (rd_en && !wr_en) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr_en)
        else $error("queue written while full");
    a_no_read_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rd_valid |-> !rd_en)
        else $error("queue read while empty");
    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> count_reg == $past(count_reg) + CntW'(1))
        else $error("queue count did not follow a write");
`endif

endmodule

`default_nettype wire

[rtl/scl_back.sv]
`default_nettype none

module scl_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire scl_pkg::entry_t q_data,
    input  wire logic            q_valid,
    output logic                 q_pop,
    input  wire logic            pop,
    output logic                 empty,
    output scl_pkg::result_t     res
);

    scl_pkg::entry_t ent_reg;
    logic            ent_valid_reg;
    logic            ent_valid_next;
    logic            idx_reg;
    logic            idx_next;
    logic            adv;
    logic            on_last;

    assign adv     = pop && ent_valid_reg;
    assign on_last = idx_reg || !ent_reg.two;
    assign q_pop   = q_valid && (!ent_valid_reg || (adv && on_last));
    assign empty   = !ent_valid_reg;
    assign res     = idx_reg ? ent_reg.r1 : ent_reg.r0;

    always_comb
    begin
        ent_valid_next = ent_valid_reg;
        idx_next       = idx_reg;
        if (adv && !on_last) begin
            idx_next = 1'b1;
        end
        else if (!ent_valid_reg || adv) begin
            ent_valid_next = q_valid;
            idx_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ent_valid_reg <= 1'b0;
            idx_reg       <= 1'b0;
        end
        else begin
            ent_valid_reg <= ent_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop) begin
            ent_reg <= q_data;
        end
    end

`ifndef SYNTHESIS
    a_second_only_if_two: assert property (@(posedge clk) disable iff (!rst_n)
        (ent_valid_reg && idx_reg) |-> ent_reg.two)
        else $error("second result shown for a single-result entry");
    a_second_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ent_valid_reg && idx_reg) |-> res.last_of_run)
        else $error("second result not marked last");
    a_idle_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (!ent_valid_reg && q_valid) |=> ent_valid_reg && !idx_reg)
        else $error("waiting entry not loaded into the output stage");
`endif

endmodule

`default_nettype wire

[rtl/sql_lexical_scanner.sv]
// SQL lexical scanner: splits statement text into a stream of token beats.
//
// Input channel: one byte of text per beat on char_code, taken at a rising
// edge with push high and full low. Output channel: while empty is low the
// oldest result beat stands on is_end, token_class, char_value, unterminated
// and last_of_run; it is taken at a rising edge with pop high.
//
// Each byte causes zero, one or two result beats. Skipped blanks and an
// opening quote cause none. A token's text beats are followed by one end
// beat carrying its class; a newline gives an end-of-statement beat.
//
// A byte's entry goes via the queue to the output register, where its first
// result shows. Throughput: one input byte per cycle while full is low, one
// result beat per cycle while pop is high; the single output port sets the
// sustained rate, so a two-result byte uses it twice. A queue of QueueDepth
// entries between classifier and output stage absorbs this; full rises only
// when it holds QueueDepth entries while the output is stalled or busy.
//
// Reset clears the scan mode to start, empties the queue and the output stage.
// When the receiver holds pop low, the shown beat stays put and full follows.
`default_nettype none

module sql_lexical_scanner #(
    parameter int QueueDepth = scl_pkg::QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] char_code,
    output logic            empty,
    input  wire logic       pop,
    output logic            is_end,
    output logic [2:0]      token_class,
    output logic [7:0]      char_value,
    output logic            unterminated,
    output logic            last_of_run
);

    scl_pkg::front_out_t front_out;
    scl_pkg::entry_t     q_data;
    scl_pkg::result_t    res;
    logic                q_valid;
    logic                q_pop;
    logic                accept;

    // A byte is taken whenever the queue has room, even while the output
    // stage waits on the receiver.
    assign accept = push && !full;

    // Front: classifies the byte, runs the scan mode and builds the entry.
    scl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_code (char_code),
        .front_out (front_out)
    );

    // Short queue that decouples classification from result delivery.
    scl_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_out.push),
        .wr_data  (front_out.entry),
        .full     (full),
        .rd_en    (q_pop),
        .rd_data  (q_data),
        .rd_valid (q_valid)
    );

    // Back: output register that hands out one result beat per pop.
    scl_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .res     (res)
    );

    assign is_end       = res.is_end;
    assign token_class  = res.token_class;
    assign char_value   = res.char_value;
    assign unterminated = res.unterminated;
    assign last_of_run  = res.last_of_run;

endmodule

`default_nettype wire
